@@ rtl/go_back_n_arq_link_core_assert.svh @@
// Assertion macros shared by the checker of the go-back-N link core.
// Needs clk and rst_n in scope where a macro is used.
`ifndef GO_BACK_N_ARQ_LINK_CORE_ASSERT_SVH
`define GO_BACK_N_ARQ_LINK_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define GBN_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("go-back-N link core: assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define GBN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("go-back-N link core: assertion failed");

`endif

@@ rtl/gbn_pkg.sv @@
// Package of the go-back-N link core: widths, codes, state encoding and structs.
// Used by every module of the block; depends on nothing.
package gbn_pkg;

    localparam int PAYLOAD_BITS = 32;
    localparam int AGE_BITS     = 24;
    localparam int LIMIT_BITS   = 24;
    localparam int SEQ_BITS     = 2;
    localparam int CNT_BITS     = SEQ_BITS + 1;
    localparam int WINDOW       = 1 << SEQ_BITS;
    localparam int CMP_BITS     = (AGE_BITS > LIMIT_BITS) ? AGE_BITS : LIMIT_BITS;
    localparam int STATUS_BITS  = 3;

    localparam int IN_TDATA_BITS  = ((SEQ_BITS + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((SEQ_BITS + PAYLOAD_BITS + STATUS_BITS + 7) / 8) * 8;
    localparam int STATUS_LSB     = SEQ_BITS + PAYLOAD_BITS;

    typedef logic [SEQ_BITS-1:0]     seq_t;
    typedef logic [CNT_BITS-1:0]     count_t;
    typedef logic [PAYLOAD_BITS-1:0] payload_t;
    typedef logic [AGE_BITS-1:0]     age_t;
    typedef logic [LIMIT_BITS-1:0]   limit_t;
    typedef logic [WINDOW-1:0]       slot_mask_t;

    localparam limit_t TIMEOUT_RESET = LIMIT_BITS'(5000000);
    localparam seq_t   DUP_ACK_DIST  = SEQ_BITS'(3);
    localparam seq_t   LAST_RX_RESET = SEQ_BITS'(3);

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_DATA = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_DELIVER = 2'd3
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_DUP_ACK   = 3'd2,
        STAT_QUEUE_ERR = 3'd3,
        STAT_DUP_DATA  = 3'd4,
        STAT_DROPPED   = 3'd5,
        STAT_RETX      = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RES,
        S_ACK2,
        S_AGE,
        S_AGE_LAST,
        S_RETX
    } state_t;

    typedef struct packed {
        kind_t    kind;
        seq_t     seq;
        payload_t payload;
        status_t  status;
        logic     last;
    } result_t;

    typedef struct packed {
        logic       pay_we;
        seq_t       pay_waddr;
        payload_t   pay_wdata;
        logic       pay_re;
        seq_t       pay_raddr;
        logic       age_we;
        seq_t       age_waddr;
        age_t       age_wdata;
        logic       age_re;
        seq_t       age_raddr;
        slot_mask_t age_clr;
    } store_req_t;

endpackage

@@ rtl/go_back_n_arq_link_core.sv @@
// Go-back-N link core with a four-frame window: stream ports, output register.
// Instantiates gbn_ctrl and gbn_store; depends on gbn_pkg.
//
// A send, ACK or received-data transaction is taken in one cycle and its result is
// offered in the next; a delivery is followed by its ACK frame, and a tick with no
// frame outstanding gives its status result the same way. A tick with N frames
// outstanding walks the age memory one slot per cycle through its single read port
// and write port, then writes back the last slot and either offers the status
// result or, on a timeout, resends the N frames from the payload memory at one per
// cycle while the output register takes them. The output register lets the next
// input transaction be taken while the last result still waits downstream. Ages
// need no clearing pass after reset.
module go_back_n_arq_link_core import gbn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // seq_num, payload, zero fill
    input  logic [1:0]                s_tuser,   // operation
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // frame_seq, frame_payload, status, zero fill
    output logic [1:0]                m_tuser,   // frame_kind
    output logic                      m_tlast,   // last
    input  logic                      cfg_we,
    input  logic [LIMIT_BITS-1:0]     cfg_wdata  // timeout_limit
);

    store_req_t req;
    payload_t   pay_rdata;
    age_t       age_rdata;
    logic       res_valid;
    logic       res_ready;
    result_t    res;
    logic       out_valid_reg;
    result_t    out_res_reg;

    gbn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (op_t'(s_tuser)),
        .in_seq     (s_tdata[SEQ_BITS-1:0]),
        .in_payload (s_tdata[SEQ_BITS +: PAYLOAD_BITS]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .req        (req),
        .pay_rdata  (pay_rdata),
        .age_rdata  (age_rdata)
    );

    gbn_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .pay_rdata (pay_rdata),
        .age_rdata (age_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_BITS'({out_res_reg.status, out_res_reg.payload,
                                       out_res_reg.seq});
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;

endmodule

@@ rtl/gbn_store.sv @@
// Window store of the go-back-N link core: payload memory and age memory.
// Both memories have registered reads; age entries carry valid bits.
// Depends on gbn_pkg.
module gbn_store import gbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output payload_t   pay_rdata,
    output age_t       age_rdata
);

    payload_t   pay_mem [WINDOW];
    age_t       age_mem [WINDOW];
    payload_t   pay_rdata_reg;
    age_t       age_rdata_reg;
    logic       age_rvalid_reg;
    slot_mask_t age_valid_reg;
    slot_mask_t age_valid_next;

    always_ff @(posedge clk)
    begin
        if (req.pay_we)
        begin
            pay_mem[req.pay_waddr] <= req.pay_wdata;
        end
        if (req.pay_re)
        begin
            pay_rdata_reg <= pay_mem[req.pay_raddr];
        end
        if (req.age_we)
        begin
            age_mem[req.age_waddr] <= req.age_wdata;
        end
        if (req.age_re)
        begin
            age_rdata_reg <= age_mem[req.age_raddr];
        end
    end

    // An age entry that is not valid reads as zero.
    always_comb
    begin
        age_valid_next = age_valid_reg & ~req.age_clr;
        if (req.age_we)
        begin
            age_valid_next[req.age_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_valid_reg  <= '0;
            age_rvalid_reg <= 1'b0;
        end
        else
        begin
            age_valid_reg <= age_valid_next;
            if (req.age_re)
            begin
                age_rvalid_reg <= age_valid_reg[req.age_raddr];
            end
        end
    end

    assign pay_rdata = pay_rdata_reg;
    assign age_rdata = age_rvalid_reg ? age_rdata_reg : '0;

endmodule

@@ rtl/gbn_ctrl.sv @@
// Sequencer of the go-back-N link core: window pointers, receiver state,
// timeout register and the state machine that drives the window store.
// Depends on gbn_pkg.
module gbn_ctrl import gbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  op_t        in_op,
    input  seq_t       in_seq,
    input  payload_t   in_payload,
    input  logic       cfg_we,
    input  limit_t     cfg_wdata,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res,
    output store_req_t req,
    input  payload_t   pay_rdata,
    input  age_t       age_rdata
);

    state_t  state_reg, state_next;
    seq_t    next_send_reg, next_send_next;
    seq_t    oldest_reg, oldest_next;
    count_t  count_reg, count_next;
    seq_t    last_rx_reg, last_rx_next;
    limit_t  limit_reg;
    result_t res_reg, res_next;
    logic    more_reg, more_next;
    seq_t    start_reg, start_next;
    count_t  cnt_reg, cnt_next;
    seq_t    idx_reg, idx_next;
    logic    pend_reg, pend_next;
    seq_t    pend_slot_reg, pend_slot_next;
    logic    expired_reg, expired_next;

    logic       accept;
    seq_t       ack_span;
    count_t     retire_n;
    logic       underflow;
    slot_mask_t ack_clr;
    seq_t       slot_cur;
    age_t       age_inc;
    logic       age_over;
    logic       last_slot;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign ack_span  = in_seq - oldest_reg;
    assign retire_n  = CNT_BITS'(ack_span) + CNT_BITS'(1);
    assign underflow = count_reg < retire_n;
    assign slot_cur  = start_reg + idx_reg;
    assign age_inc   = (age_rdata == '1) ? age_rdata : age_rdata + AGE_BITS'(1);
    assign age_over  = CMP_BITS'(age_inc) > CMP_BITS'(limit_reg);
    assign last_slot = CNT_BITS'(idx_reg) == (cnt_reg - CNT_BITS'(1));

    always_comb
    begin
        ack_clr = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (SEQ_BITS'(i) <= ack_span)
            begin
                ack_clr[oldest_reg + SEQ_BITS'(i)] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((in_op == OP_TICK) && (count_reg != '0))
                    begin
                        state_next = S_AGE;
                    end
                    else
                    begin
                        state_next = S_RES;
                    end
                end
            end
            S_RES:
            begin
                if (res_ready)
                begin
                    state_next = more_reg ? S_ACK2 : S_IDLE;
                end
            end
            S_ACK2:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_AGE:
            begin
                if (last_slot)
                begin
                    state_next = S_AGE_LAST;
                end
            end
            S_AGE_LAST:
            begin
                state_next = (expired_reg || age_over) ? S_RETX : S_RES;
            end
            S_RETX:
            begin
                if (res_ready && last_slot)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        next_send_next = next_send_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        last_rx_next   = last_rx_reg;
        res_next       = res_reg;
        more_next      = more_reg;
        start_next     = start_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        expired_next   = expired_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        res            = res_reg;
        req            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    more_next = 1'b0;
                    unique case (in_op)
                        OP_SEND:
                        begin
                            if (count_reg >= CNT_BITS'(WINDOW))
                            begin
                                res_next = '{KIND_STATUS, next_send_reg, '0, STAT_FULL, 1'b1};
                            end
                            else
                            begin
                                req.pay_we     = 1'b1;
                                req.pay_waddr  = next_send_reg;
                                req.pay_wdata  = in_payload;
                                req.age_clr    = slot_mask_t'(1) << next_send_reg;
                                count_next     = count_reg + CNT_BITS'(1);
                                next_send_next = next_send_reg + SEQ_BITS'(1);
                                res_next = '{KIND_DATA, next_send_reg, in_payload, STAT_OK, 1'b1};
                            end
                        end
                        OP_ACK:
                        begin
                            if (ack_span >= DUP_ACK_DIST)
                            begin
                                res_next = '{KIND_STATUS, in_seq, '0, STAT_DUP_ACK, 1'b1};
                            end
                            else
                            begin
                                req.age_clr = ack_clr;
                                count_next  = underflow ? '0 : count_reg - retire_n;
                                oldest_next = oldest_reg + retire_n[SEQ_BITS-1:0];
                                res_next = '{KIND_STATUS, in_seq, '0,
                                             underflow ? STAT_QUEUE_ERR : STAT_OK, 1'b1};
                            end
                        end
                        OP_DATA:
                        begin
                            if (in_seq == (last_rx_reg + SEQ_BITS'(1)))
                            begin
                                last_rx_next = in_seq;
                                more_next    = 1'b1;
                                res_next = '{KIND_DELIVER, in_seq, in_payload, STAT_OK, 1'b0};
                            end
                            else if (in_seq == last_rx_reg)
                            begin
                                res_next = '{KIND_ACK, in_seq, '0, STAT_DUP_DATA, 1'b1};
                            end
                            else
                            begin
                                res_next = '{KIND_STATUS, in_seq, '0, STAT_DROPPED, 1'b1};
                            end
                        end
                        OP_TICK:
                        begin
                            res_next     = '{KIND_STATUS, '0, '0, STAT_OK, 1'b1};
                            start_next   = next_send_reg - count_reg[SEQ_BITS-1:0];
                            cnt_next     = count_reg;
                            idx_next     = '0;
                            pend_next    = 1'b0;
                            expired_next = 1'b0;
                        end
                        default:
                        begin
                            res_next = res_reg;
                        end
                    endcase
                end
            end
            S_RES:
            begin
                res_valid = 1'b1;
                res       = res_reg;
            end
            S_ACK2:
            begin
                res_valid = 1'b1;
                res       = '{KIND_ACK, res_reg.seq, '0, STAT_OK, 1'b1};
            end
            S_AGE:
            begin
                // Read one slot while the previous slot's aged value is written back.
                req.age_re    = 1'b1;
                req.age_raddr = slot_cur;
                if (pend_reg)
                begin
                    req.age_we    = 1'b1;
                    req.age_waddr = pend_slot_reg;
                    req.age_wdata = age_inc;
                    expired_next  = expired_reg || age_over;
                end
                pend_next      = 1'b1;
                pend_slot_next = slot_cur;
                idx_next       = last_slot ? '0 : idx_reg + SEQ_BITS'(1);
            end
            S_AGE_LAST:
            begin
                req.age_we    = 1'b1;
                req.age_waddr = pend_slot_reg;
                req.age_wdata = age_inc;
                pend_next     = 1'b0;
                if (expired_reg || age_over)
                begin
                    req.pay_re    = 1'b1;
                    req.pay_raddr = start_reg;
                end
            end
            S_RETX:
            begin
                res_valid = 1'b1;
                res       = '{KIND_DATA, slot_cur, pay_rdata, STAT_RETX, last_slot};
                if (res_ready)
                begin
                    req.age_clr = slot_mask_t'(1) << slot_cur;
                    if (!last_slot)
                    begin
                        idx_next      = idx_reg + SEQ_BITS'(1);
                        req.pay_re    = 1'b1;
                        req.pay_raddr = slot_cur + SEQ_BITS'(1);
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_send_reg <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            last_rx_reg   <= LAST_RX_RESET;
            limit_reg     <= TIMEOUT_RESET;
            more_reg      <= 1'b0;
            start_reg     <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_slot_reg <= '0;
            expired_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_send_reg <= next_send_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            last_rx_reg   <= last_rx_next;
            more_reg      <= more_next;
            start_reg     <= start_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_slot_reg <= pend_slot_next;
            expired_reg   <= expired_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

@@ rtl/gbn_checker.sv @@
// Port checker of the go-back-N link core, bound to the top level.
// Depends on gbn_pkg and go_back_n_arq_link_core_assert.svh.
`include "go_back_n_arq_link_core_assert.svh"

module gbn_checker import gbn_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_TDATA_BITS-1:0] m_tdata,
    input logic [1:0]                m_tuser,
    input logic                      m_tlast
);

    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [STATUS_BITS-1:0]  out_status;

    assign out_payload = m_tdata[SEQ_BITS +: PAYLOAD_BITS];
    assign out_status  = m_tdata[STATUS_LSB +: STATUS_BITS];

    `GBN_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid)
    `GBN_ASSERT_IMPL(a_ack_no_payload, m_tvalid && (m_tuser == KIND_ACK), out_payload == '0)
    `GBN_ASSERT_IMPL(a_deliver_not_last, m_tvalid && (m_tuser == KIND_DELIVER), !m_tlast)
    `GBN_ASSERT_IMPL(a_retx_is_data, m_tvalid && (out_status == STAT_RETX), m_tuser == KIND_DATA)

endmodule

bind go_back_n_arq_link_core gbn_checker u_gbn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the go-back-N link core: a short table of directed transactions,
// then random phases under several timeout limits, checked against a predictor.
// Depends on gbn_pkg and go_back_n_arq_link_core.
module testbench import gbn_pkg::*;
    ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam result_t NO_FRAME = '0;
    localparam limit_t PHASE_LIMITS [4] = '{24'd3, 24'd1, 24'hFFFFFF, 24'd2};

    typedef struct {
        logic     set_limit;
        limit_t   limit_val;
        op_t      op;
        seq_t     seq;
        payload_t pay;
        logic     pinned;
        result_t  want;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic [1:0]                s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic [1:0]                m_tuser;
    logic                      m_tlast;
    logic                      cfg_we = 1'b0;
    logic [LIMIT_BITS-1:0]     cfg_wdata = '0;

    // Predicted state of the link.
    seq_t     nxt_seq;
    seq_t     oldest_seq;
    count_t   outst;
    seq_t     last_rx;
    payload_t win_pay [WINDOW];
    age_t     ages [WINDOW];
    limit_t   tmo_limit;

    result_t step_frames [$];
    result_t expected_frames [$];
    result_t head_frame;
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    bit      no_gaps = 1'b0;

    stim_row_t directed_rows [24] = '{
        '{0, 0, OP_TICK, 2'd0, 32'h0, 1, '{KIND_STATUS, 2'd0, 32'h0, STAT_OK, 1'b1}},
        '{0, 0, OP_ACK,  2'd0, 32'h0, 1, '{KIND_STATUS, 2'd0, 32'h0, STAT_QUEUE_ERR, 1'b1}},
        '{0, 0, OP_DATA, 2'd0, 32'hFFFFFFFF, 0, NO_FRAME},
        '{0, 0, OP_DATA, 2'd0, 32'h0, 1, '{KIND_ACK, 2'd0, 32'h0, STAT_DUP_DATA, 1'b1}},
        '{0, 0, OP_DATA, 2'd2, 32'h0F0F0F0F, 1, '{KIND_STATUS, 2'd2, 32'h0, STAT_DROPPED, 1'b1}},
        '{0, 0, OP_DATA, 2'd1, 32'h0, 0, NO_FRAME},
        '{0, 0, OP_SEND, 2'd3, 32'h0, 0, NO_FRAME},
        '{0, 0, OP_SEND, 2'd0, 32'hFFFFFFFF, 0, NO_FRAME},
        '{0, 0, OP_SEND, 2'd0, 32'hA5A5A5A5, 0, NO_FRAME},
        '{0, 0, OP_SEND, 2'd0, 32'h5A5A5A5A, 0, NO_FRAME},
        '{0, 0, OP_SEND, 2'd0, 32'h12345678, 1, '{KIND_STATUS, 2'd0, 32'h0, STAT_FULL, 1'b1}},
        '{0, 0, OP_ACK,  2'd0, 32'h0, 1, '{KIND_STATUS, 2'd0, 32'h0, STAT_DUP_ACK, 1'b1}},
        '{0, 0, OP_TICK, 2'd0, 32'h0, 1, '{KIND_STATUS, 2'd0, 32'h0, STAT_OK, 1'b1}},
        '{1, 24'd1, OP_TICK, 2'd0, 32'h0, 0, NO_FRAME},
        '{0, 0, OP_ACK,  2'd2, 32'h0, 0, NO_FRAME},
        '{0, 0, OP_TICK, 2'd0, 32'h0, 0, NO_FRAME},
        '{0, 0, OP_TICK, 2'd0, 32'h0, 0, NO_FRAME},
        '{0, 0, OP_ACK,  2'd1, 32'h0, 0, NO_FRAME},
        '{0, 0, OP_DATA, 2'd2, 32'h00C0FFEE, 0, NO_FRAME},
        '{0, 0, OP_DATA, 2'd3, 32'h80000001, 0, NO_FRAME},
        '{0, 0, OP_DATA, 2'd1, 32'h0, 1, '{KIND_STATUS, 2'd1, 32'h0, STAT_DROPPED, 1'b1}},
        '{1, 24'hFFFFFF, OP_TICK, 2'd0, 32'h0, 1,
          '{KIND_STATUS, 2'd0, 32'h0, STAT_OK, 1'b1}},
        '{0, 0, OP_SEND, 2'd1, 32'hDEADBEEF, 0, NO_FRAME},
        '{0, 0, OP_TICK, 2'd0, 32'h0, 1, '{KIND_STATUS, 2'd0, 32'h0, STAT_OK, 1'b1}}
    };

    go_back_n_arq_link_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic void emit(kind_t k, seq_t s, payload_t p, status_t st);
        step_frames.push_back('{k, s, p, st, 1'b0});
    endfunction

    function automatic void link_predict(op_t op, seq_t seq, payload_t pay);
        seq_t ack_span;
        seq_t slot;
        seq_t start;
        seq_t want_rx;
        logic underflow;
        logic expired;
        step_frames.delete();
        unique case (op)
            OP_SEND:
            begin
                if (outst >= count_t'(WINDOW))
                begin
                    emit(KIND_STATUS, nxt_seq, '0, STAT_FULL);
                end
                else
                begin
                    win_pay[nxt_seq] = pay;
                    ages[nxt_seq] = '0;
                    outst = outst + 1'b1;
                    emit(KIND_DATA, nxt_seq, pay, STAT_OK);
                    nxt_seq = nxt_seq + 1'b1;
                end
            end
            OP_ACK:
            begin
                ack_span = seq - oldest_seq;
                if (ack_span >= DUP_ACK_DIST)
                begin
                    emit(KIND_STATUS, seq, '0, STAT_DUP_ACK);
                end
                else
                begin
                    underflow = 1'b0;
                    for (int i = 0; i <= int'(ack_span); i++)
                    begin
                        ages[oldest_seq] = '0;
                        if (outst == '0)
                            underflow = 1'b1;
                        else
                            outst = outst - 1'b1;
                        oldest_seq = oldest_seq + 1'b1;
                    end
                    emit(KIND_STATUS, seq, '0, underflow ? STAT_QUEUE_ERR : STAT_OK);
                end
            end
            OP_DATA:
            begin
                want_rx = last_rx + 1'b1;
                if (seq == want_rx)
                begin
                    last_rx = seq;
                    emit(KIND_DELIVER, seq, pay, STAT_OK);
                    emit(KIND_ACK, seq, '0, STAT_OK);
                end
                else if (seq == last_rx)
                begin
                    emit(KIND_ACK, seq, '0, STAT_DUP_DATA);
                end
                else
                begin
                    emit(KIND_STATUS, seq, '0, STAT_DROPPED);
                end
            end
            default:
            begin
                start = nxt_seq - seq_t'(outst);
                expired = 1'b0;
                for (int i = 0; i < int'(outst); i++)
                begin
                    slot = start + seq_t'(i);
                    if (ages[slot] != '1)
                        ages[slot] = ages[slot] + 1'b1;
                    if (ages[slot] > tmo_limit)
                        expired = 1'b1;
                end
                if (expired)
                begin
                    for (int i = 0; i < int'(outst); i++)
                    begin
                        slot = start + seq_t'(i);
                        emit(KIND_DATA, slot, win_pay[slot], STAT_RETX);
                        ages[slot] = '0;
                    end
                end
                else
                begin
                    emit(KIND_STATUS, '0, '0, STAT_OK);
                end
            end
        endcase
        step_frames[step_frames.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch in %s: got %0h, wanted %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic run_item(op_t op, seq_t seq, payload_t pay, logic pinned, result_t want);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_TDATA_BITS'({pay, seq});
        do
            @(posedge clk);
        while (!s_tready);
        link_predict(op, seq, pay);
        if (pinned)
            expected_frames.push_back(want);
        else
            foreach (step_frames[j])
                expected_frames.push_back(step_frames[j]);
    endtask

    task automatic set_timeout(limit_t value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tmo_limit = value;
    endtask

    // Mostly well-formed traffic: acknowledgements within the window and in-order data.
    task automatic random_item();
        int   pick;
        op_t  op;
        seq_t seq;
        pick = $urandom_range(99);
        seq  = seq_t'($urandom_range(3));
        if (pick < 30)
        begin
            op = OP_SEND;
        end
        else if (pick < 55)
        begin
            op = OP_ACK;
            if (outst != '0)
                seq = oldest_seq + seq_t'($urandom_range(int'(outst) - 1));
        end
        else if (pick < 75)
        begin
            op = OP_DATA;
            if ($urandom_range(9) < 8)
                seq = last_rx + 1'b1;
        end
        else if (pick < 95)
        begin
            op = OP_TICK;
        end
        else
        begin
            op = op_t'($urandom_range(3));
        end
        run_item(op, seq, $urandom(), 1'b0, NO_FRAME);
    endtask

    always @(negedge clk)
        m_tready <= no_gaps || ($urandom_range(99) >= 22);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_frames.size() == 0)
            begin
                report_mismatch("unexpected result transaction", 64'(m_tdata), 64'(0));
            end
            else
            begin
                head_frame = expected_frames.pop_front();
                if (m_tuser !== head_frame.kind)
                    report_mismatch("frame_kind", 64'(m_tuser), 64'(head_frame.kind));
                if (m_tdata[SEQ_BITS-1:0] !== head_frame.seq)
                    report_mismatch("frame_seq", 64'(m_tdata[SEQ_BITS-1:0]),
                                    64'(head_frame.seq));
                if (m_tdata[SEQ_BITS +: PAYLOAD_BITS] !== head_frame.payload)
                    report_mismatch("frame_payload", 64'(m_tdata[SEQ_BITS +: PAYLOAD_BITS]),
                                    64'(head_frame.payload));
                if (m_tdata[STATUS_LSB +: STATUS_BITS] !== head_frame.status)
                    report_mismatch("status", 64'(m_tdata[STATUS_LSB +: STATUS_BITS]),
                                    64'(head_frame.status));
                if (m_tlast !== head_frame.last)
                    report_mismatch("last", 64'(m_tlast), 64'(head_frame.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** go_back_n_arq_link_core: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        nxt_seq    = '0;
        oldest_seq = '0;
        outst      = '0;
        last_rx    = LAST_RX_RESET;
        tmo_limit  = TIMEOUT_RESET;
        foreach (ages[k])
        begin
            ages[k]    = '0;
            win_pay[k] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].set_limit)
                set_timeout(directed_rows[k].limit_val);
            run_item(directed_rows[k].op, directed_rows[k].seq, directed_rows[k].pay,
                     directed_rows[k].pinned, directed_rows[k].want);
        end

        // One phase per limit; the second runs with no idling on either side.
        foreach (PHASE_LIMITS[p])
        begin
            set_timeout(PHASE_LIMITS[p]);
            no_gaps = (p == 1);
            repeat (24) random_item();
            no_gaps = 1'b0;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("** go_back_n_arq_link_core: PASSED **");
        else
            $display("** go_back_n_arq_link_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gbn_pkg.sv
rtl/gbn_store.sv
rtl/gbn_ctrl.sv
rtl/go_back_n_arq_link_core.sv
rtl/gbn_checker.sv
tb/testbench.sv
